// File: sv/tafa_pkg.sv
// Shared types and constants for the tilt angle unit: controller states,
// command and status bundles, datapath widths and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package tafa_pkg;

    localparam int FIELD_W   = 16;
    localparam int YAW_W     = 48;
    localparam int PROD_W    = 33;             // gyro_z * dt_us, signed
    localparam int SQ_W      = 31;             // square of a 16-bit count
    localparam int SUM_W     = 32;             // sum of two squares
    localparam int ROOT_W    = 16;             // floor square root of SUM_W bits
    localparam int REM_W     = 18;
    localparam int NUM_W     = 17;             // numerator incl. negated -32768
    localparam int PRE_SHIFT = 20;             // CORDIC prescale 2^20
    localparam int CW        = 40;             // CORDIC x/y width
    localparam int ATAN_W    = 23;
    localparam int ZW        = 26;             // angle accumulator, 1/65536 deg
    localparam int QW        = ZW - 7;         // rounded angle, 1/256 deg
    localparam int TABLE_LEN = 24;
    localparam int CNT_W     = $clog2(TABLE_LEN);
    localparam int ANGLE_LIMIT = 23040;
    localparam int ROUND_BIAS  = 128;
    localparam int MUL_OPS     = 4;
    localparam int LANES       = 2;            // pitch, roll

    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;

    localparam logic [1:0] MUL_SEL_AX = 2'd0;
    localparam logic [1:0] MUL_SEL_AY = 2'd1;
    localparam logic [1:0] MUL_SEL_AZ = 2'd2;
    localparam logic [1:0] MUL_SEL_GZ = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SQRT,
        ST_CINIT,
        ST_CORDIC,
        ST_DONE
    } tafa_state_t;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic cnt_inc;
        logic mul_en;
        logic isq_init;
        logic isq_step;
        logic cor_init;
        logic cor_step;
        logic finish;
    } tafa_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic sqrt_last;
        logic cor_last;
    } tafa_status_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/tafa_in_if.sv
// Input channel: one accelerometer/gyro sample word with valid/ready.
// Depends on tafa_pkg.
`timescale 1ns / 1ps

interface tafa_in_if
    import tafa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  accel_x;
    logic signed [FIELD_W-1:0]  accel_y;
    logic signed [FIELD_W-1:0]  accel_z;
    logic signed [FIELD_W-1:0]  gyro_z;
    logic        [FIELD_W-1:0]  dt_us;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_z, dt_us,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_z, dt_us,
        output ready
    );
endinterface

// File: sv/tafa_out_if.sv
// Output channel: one pitch/roll/yaw result word with valid/ready.
// Depends on tafa_pkg.
`timescale 1ns / 1ps

interface tafa_out_if
    import tafa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  pitch_angle;
    logic signed [FIELD_W-1:0]  roll_angle;
    logic signed [YAW_W-1:0]    yaw_sum;

    modport source (
        output valid, pitch_angle, roll_angle, yaw_sum,
        input  ready
    );

    modport sink (
        input  valid, pitch_angle, roll_angle, yaw_sum,
        output ready
    );
endinterface

// File: sv/tafa_ctrl.sv
// Sequencer for the tilt angle unit: walks multiply, square root and CORDIC
// phases and owns the result valid flag. Depends on tafa_pkg.
`timescale 1ns / 1ps

module tafa_ctrl
    import tafa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_valid,
    output logic         sample_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  tafa_status_t status,
    output tafa_cmd_t    cmd
);

    tafa_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.mul_last)
                    state_next = ST_SUM;
            end
            ST_SUM:
                state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (status.sqrt_last)
                    state_next = ST_CINIT;
            end
            ST_CINIT:
                state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (status.cor_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.load     = sample_valid;
                cmd.cnt_clr  = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_SUM:
            begin
                cmd.isq_init = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_SQRT:
            begin
                cmd.isq_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_CINIT:
            begin
                cmd.cor_init = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_CORDIC:
            begin
                cmd.cor_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
            end
            ST_DONE:
                cmd.finish = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // set on a new result, drop once the word is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/tafa_dpath.sv
// Datapath of the tilt angle unit: shared multiplier, two bit-serial square
// roots, two iterative CORDIC lanes and the saturating yaw sum. Uses tafa_pkg.
`timescale 1ns / 1ps

module tafa_dpath
    import tafa_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tafa_cmd_t                  cmd,
    output tafa_status_t               status,
    input  logic signed [FIELD_W-1:0]  accel_x,
    input  logic signed [FIELD_W-1:0]  accel_y,
    input  logic signed [FIELD_W-1:0]  accel_z,
    input  logic signed [FIELD_W-1:0]  gyro_z,
    input  logic        [FIELD_W-1:0]  dt_us,
    output logic signed [FIELD_W-1:0]  pitch_angle,
    output logic signed [FIELD_W-1:0]  roll_angle,
    output logic signed [YAW_W-1:0]    yaw_sum
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // sample hold
    logic signed [FIELD_W-1:0] ax_reg, ay_reg, az_reg, gz_reg;
    logic        [FIELD_W-1:0] dt_reg;
    logic        [CNT_W-1:0]   cnt_reg, cnt_next;

    // products
    logic signed [FIELD_W:0]    mul_a, mul_b;
    logic signed [2*FIELD_W+1:0] mul_p;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    // square root lanes
    logic [SUM_W-1:0]  val_reg  [LANES];
    logic [REM_W-1:0]  rem_reg  [LANES];
    logic [ROOT_W-1:0] root_reg [LANES];
    logic [SUM_W-1:0]  val_next [LANES];
    logic [REM_W-1:0]  rem_next [LANES];
    logic [ROOT_W-1:0] root_next[LANES];
    logic [REM_W:0]    isq_cand [LANES];
    logic [REM_W:0]    isq_trial[LANES];
    logic [REM_W:0]    isq_diff [LANES];
    logic              isq_ge   [LANES];
    logic [SUM_W-1:0]  sum_init [LANES];

    // CORDIC lanes
    logic signed [CW-1:0]  x_reg  [LANES];
    logic signed [CW-1:0]  y_reg  [LANES];
    logic signed [ZW-1:0]  z_reg  [LANES];
    logic signed [CW-1:0]  x_next [LANES];
    logic signed [CW-1:0]  y_next [LANES];
    logic signed [ZW-1:0]  z_next [LANES];
    logic signed [CW-1:0]  xs     [LANES];
    logic signed [CW-1:0]  ys     [LANES];
    logic signed [ZW-1:0]  step_angle;
    logic signed [NUM_W-1:0] num  [LANES];

    // result forming
    logic signed [ZW:0]          zsum  [LANES];
    logic signed [QW-1:0]        zq    [LANES];
    logic signed [FIELD_W-1:0]   angle [LANES];
    logic                        all_zero;
    logic signed [YAW_W:0]       yaw_add;
    logic signed [YAW_W-1:0]     yaw_sat;
    logic signed [YAW_W-1:0]     yaw_reg;
    logic signed [FIELD_W-1:0]   pitch_reg, roll_reg;

    assign status.mul_last  = (cnt_reg == CNT_W'(MUL_OPS - 1));
    assign status.sqrt_last = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign status.cor_last  = (cnt_reg == CNT_W'(STEPS - 1));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
    end

    // one shared multiplier, operand pair picked by the phase counter
    always_comb
    begin
        case (cnt_reg[1:0])
            MUL_SEL_AX:
            begin
                mul_a = {ax_reg[FIELD_W-1], ax_reg};
                mul_b = {ax_reg[FIELD_W-1], ax_reg};
            end
            MUL_SEL_AY:
            begin
                mul_a = {ay_reg[FIELD_W-1], ay_reg};
                mul_b = {ay_reg[FIELD_W-1], ay_reg};
            end
            MUL_SEL_AZ:
            begin
                mul_a = {az_reg[FIELD_W-1], az_reg};
                mul_b = {az_reg[FIELD_W-1], az_reg};
            end
            default:
            begin
                mul_a = {gz_reg[FIELD_W-1], gz_reg};
                mul_b = signed'({1'b0, dt_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign sum_init[LANE_PITCH] = {1'b0, sqx_reg} + {1'b0, sqz_reg};
    assign sum_init[LANE_ROLL]  = {1'b0, sqy_reg} + {1'b0, sqz_reg};

    // restoring square root, one result bit per cycle
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            isq_cand[l]  = {rem_reg[l][REM_W-2:0], val_reg[l][SUM_W-1 -: 2]};
            isq_trial[l] = {1'b0, root_reg[l], 2'b01};
            isq_ge[l]    = (isq_cand[l] >= isq_trial[l]);
            isq_diff[l]  = isq_cand[l] - isq_trial[l];
            rem_next[l]  = isq_ge[l] ? isq_diff[l][REM_W-1:0] : isq_cand[l][REM_W-1:0];
            root_next[l] = {root_reg[l][ROOT_W-2:0], isq_ge[l]};
            val_next[l]  = {val_reg[l][SUM_W-3:0], 2'b00};
        end
    end

    assign num[LANE_PITCH] = {ay_reg[FIELD_W-1], ay_reg};
    assign num[LANE_ROLL]  = -{ax_reg[FIELD_W-1], ax_reg};

    assign step_angle = signed'({{(ZW-ATAN_W){1'b0}}, atan_entry(cnt_reg)});

    // vectoring CORDIC: rotate towards y = 0
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            xs[l] = x_reg[l] >>> cnt_reg;
            ys[l] = y_reg[l] >>> cnt_reg;
            if (!y_reg[l][CW-1])
            begin
                x_next[l] = x_reg[l] + ys[l];
                y_next[l] = y_reg[l] - xs[l];
                z_next[l] = z_reg[l] + step_angle;
            end
            else
            begin
                x_next[l] = x_reg[l] - ys[l];
                y_next[l] = y_reg[l] + xs[l];
                z_next[l] = z_reg[l] - step_angle;
            end
        end
    end

    // both angles see zero/zero exactly when the whole triple is zero
    assign all_zero = (ax_reg == '0) && (ay_reg == '0) && (az_reg == '0);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            zsum[l] = {z_reg[l][ZW-1], z_reg[l]} + (ZW+1)'(ROUND_BIAS);
            zq[l]   = zsum[l][ZW:8];
            if (all_zero)
                angle[l] = '0;
            else if (zq[l] > QW'(ANGLE_LIMIT))
                angle[l] = FIELD_W'(ANGLE_LIMIT);
            else if (zq[l] < -QW'(ANGLE_LIMIT))
                angle[l] = -FIELD_W'(ANGLE_LIMIT);
            else
                angle[l] = zq[l][FIELD_W-1:0];
        end
    end

    // saturate on signed overflow of the 48-bit sum
    assign yaw_add = {yaw_reg[YAW_W-1], yaw_reg}
                   + {{(YAW_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        if (yaw_add[YAW_W] != yaw_add[YAW_W-1])
            yaw_sat = yaw_add[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}}
                                     : {1'b0, {(YAW_W-1){1'b1}}};
        else
            yaw_sat = yaw_add[YAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            yaw_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.finish)
                yaw_reg <= yaw_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gz_reg <= gyro_z;
            dt_reg <= dt_us;
        end

        if (cmd.mul_en)
        begin
            case (cnt_reg[1:0])
                MUL_SEL_AX: sqx_reg  <= mul_p[SQ_W-1:0];
                MUL_SEL_AY: sqy_reg  <= mul_p[SQ_W-1:0];
                MUL_SEL_AZ: sqz_reg  <= mul_p[SQ_W-1:0];
                default:    prod_reg <= mul_p[PROD_W-1:0];
            endcase
        end

        for (int l = 0; l < LANES; l++)
        begin
            if (cmd.isq_init)
            begin
                val_reg[l]  <= sum_init[l];
                rem_reg[l]  <= '0;
                root_reg[l] <= '0;
            end
            else if (cmd.isq_step)
            begin
                val_reg[l]  <= val_next[l];
                rem_reg[l]  <= rem_next[l];
                root_reg[l] <= root_next[l];
            end

            if (cmd.cor_init)
            begin
                x_reg[l] <= signed'({{(CW-ROOT_W-PRE_SHIFT){1'b0}}, root_reg[l],
                                     {PRE_SHIFT{1'b0}}});
                y_reg[l] <= {{(CW-NUM_W-PRE_SHIFT){num[l][NUM_W-1]}}, num[l],
                             {PRE_SHIFT{1'b0}}};
                z_reg[l] <= '0;
            end
            else if (cmd.cor_step)
            begin
                x_reg[l] <= x_next[l];
                y_reg[l] <= y_next[l];
                z_reg[l] <= z_next[l];
            end
        end

        if (cmd.finish)
        begin
            pitch_reg <= angle[LANE_PITCH];
            roll_reg  <= angle[LANE_ROLL];
        end
    end

    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign yaw_sum     = yaw_reg;

endmodule

// File: sv/tilt_angles_from_accel_unit.sv
// Tilt angles (pitch, roll) from a raw accelerometer triple plus a saturating yaw sum.
// Each sample word passes multiply, sum, square root, CORDIC load, rotate and finish.
// A new word is taken only when the sequencer is idle again, so the pace is set by the
// square root and CORDIC loops. A waiting result does not block taking the next sample,
// but that sample's result is held in the finish phase until the waiting one is taken.
// Reset (rst_n low, asynchronous) clears the sequencer, the result valid and the yaw sum.
`timescale 1ns / 1ps

module tilt_angles_from_accel_unit
    import tafa_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    tafa_in_if.sink     sample,
    tafa_out_if.source  result
);

    tafa_cmd_t    cmd;
    tafa_status_t status;

    tafa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    tafa_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .gyro_z      (sample.gyro_z),
        .dt_us       (sample.dt_us),
        .pitch_angle (result.pitch_angle),
        .roll_angle  (result.roll_angle),
        .yaw_sum     (result.yaw_sum)
    );

endmodule
